### design/length_prefixed_frame_ring_writer_defines.svh
// Assertion macros used by the ring writer control file, lpfw_ctrl.sv.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef LENGTH_PREFIXED_FRAME_RING_WRITER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RING_WRITER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define LPFW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LPFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lpfw_pkg.sv
package lpfw_pkg;

  // Ring geometry
  localparam int ADDR_W     = 12;
  localparam int RING_BYTES = 1 << ADDR_W;
  localparam int DATA_W     = 8;
  localparam int FLEN_W     = 16;
  localparam int LEN_W      = 32;
  localparam int PFX_BYTES  = 4;
  // Largest payload for which 4 + length still fits in RING_BYTES - 1
  localparam int MAX_FLEN   = RING_BYTES - 1 - PFX_BYTES;

  // Sequencer count: prefix bytes plus the first payload byte
  localparam int CNT_W      = 3;
  localparam int LEN_IDX_W  = $clog2(PFX_BYTES - 1);

  localparam logic [CNT_W-1:0] SLOT_LEN_LO = 3'd0;
  localparam logic [CNT_W-1:0] SLOT_LEN_HI = 3'd1;
  localparam logic [CNT_W-1:0] SLOT_PAD_LO = 3'd2;
  localparam logic [CNT_W-1:0] SLOT_PAD_HI = 3'd3;
  localparam logic [CNT_W-1:0] SLOT_DATA   = 3'd4;

  // Slave stream layout
  localparam int S_DATA_LSB  = 0;
  localparam int S_FLEN_LSB  = S_DATA_LSB + DATA_W;
  localparam int S_RADDR_LSB = S_FLEN_LSB + FLEN_W;
  localparam int S_TDATA_W   = ((S_RADDR_LSB + ADDR_W + 7) / 8) * 8;
  localparam int S_USER_FUNC  = 0;
  localparam int S_USER_FIRST = 1;
  localparam int S_TUSER_W    = 2;

  // Master stream layout
  localparam int M_RDATA_LSB = 0;
  localparam int M_HEAD_LSB  = M_RDATA_LSB + DATA_W;
  localparam int M_TAIL_LSB  = M_HEAD_LSB + ADDR_W;
  localparam int M_TDATA_W   = ((M_TAIL_LSB + ADDR_W + 7) / 8) * 8;
  localparam int M_TUSER_W   = 1;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_READ   = 1'b1
  } lpfw_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DROP,
    ST_WRITE,
    ST_OUT
  } lpfw_state_e;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } lpfw_mem_req_t;

endpackage

### design/length_prefixed_frame_ring_writer.sv
// Payload word or read word: passes ST_OUT into the result register, one item at a time.
// Frame-start word: each frame dropped at the tail costs four prefix reads plus one room
//   check through the single ring read port.
// A stalled output holds the sequencer in its result state; no new word is taken until it drains.
// Reset clears head, tail, open-frame state and the output valid; ring contents stay
//   undefined until written, with no clearing pass.
module length_prefixed_frame_ring_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: data_byte[7:0], frame_length[23:8], read_address[35:24], zero pad
  input  logic [lpfw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[0], first_byte[1]
  input  logic [lpfw_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: read_data[7:0], head_index[19:8], tail_index[31:20]
  output logic [lpfw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: oversize_error[0]
  output logic [lpfw_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // tlast: frame_done
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import lpfw_pkg::*;

  // Byte ring: one write and one registered read per cycle. The sequencer never
  // issues both in the same cycle, and a read issued after a write sees the new
  // byte, so no forwarding path is needed.
  logic [DATA_W-1:0] ring_mem [RING_BYTES];
  logic [DATA_W-1:0] ring_rdata_q;

  lpfw_mem_req_t mem_req;

  // Write the addressed byte; entries never written hold whatever powered up.
  always_ff @(posedge clk_i) begin
    if (mem_req.we) begin
      ring_mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Hold the read data until the next read, so the result stage can pick it up
  // however long the output stalls.
  always_ff @(posedge clk_i) begin
    if (mem_req.re) begin
      ring_rdata_q <= ring_mem[mem_req.raddr];
    end
  end

  // Sequencer: decode the word, drop old frames by walking prefixes at the
  // tail, write prefix and payload at the head, then publish the result.
  lpfw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (ring_rdata_q)
  );

endmodule

### design/lpfw_ctrl.sv
`include "length_prefixed_frame_ring_writer_defines.svh"

module lpfw_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: data_byte, frame_length, read_address (lowest bit up)
  input  logic [lpfw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func, first_byte (lowest bit up)
  input  logic [lpfw_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: read_data, head_index, tail_index (lowest bit up)
  output logic [lpfw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: oversize_error
  output logic [lpfw_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // tlast: frame_done
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output lpfw_pkg::lpfw_mem_req_t         mem_req_o,
  input  logic [lpfw_pkg::DATA_W-1:0]     mem_rdata_i
);
  import lpfw_pkg::*;

  lpfw_state_e state_q, state_d;

  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [FLEN_W-1:0] rem_q, rem_d;
  logic              disc_q, disc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [FLEN_W-1:0] flen_q, flen_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [PFX_BYTES-2:0][DATA_W-1:0] len_q, len_d;

  logic res_read_q, res_read_d;
  logic res_done_q, res_done_d;
  logic res_over_q, res_over_d;

  logic [M_TDATA_W-1:0] m_tdata_q, m_tdata_d;
  logic                 m_tlast_q, m_tlast_d;
  logic [M_TUSER_W-1:0] m_tuser_q, m_tuser_d;
  logic                 m_tvalid_q, m_tvalid_d;

  lpfw_mem_req_t mem_req;

  logic              in_acc;
  lpfw_func_e        in_func;
  logic              in_first;
  logic [DATA_W-1:0] in_data;
  logic [FLEN_W-1:0] in_flen;
  logic [ADDR_W-1:0] in_raddr;
  logic              in_opens;

  logic [ADDR_W-1:0] used;
  logic [ADDR_W-1:0] free;
  logic [FLEN_W:0]   need;
  logic              room_ok;
  logic              out_free;
  logic              drop_last;

  logic [LEN_W-1:0]  len_full;
  logic              len_big;
  logic [ADDR_W:0]   skip_lo;
  logic              drop_all;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_func  = lpfw_func_e'(s_axis_tuser[S_USER_FUNC]);
  assign in_first = s_axis_tuser[S_USER_FIRST];
  assign in_data  = s_axis_tdata[S_DATA_LSB +: DATA_W];
  assign in_flen  = s_axis_tdata[S_FLEN_LSB +: FLEN_W];
  assign in_raddr = s_axis_tdata[S_RADDR_LSB +: ADDR_W];
  // Frame start that fits: needs the drop loop and the prefix write
  assign in_opens = (in_func == FUNC_APPEND) && in_first && (in_flen != '0) &&
                    (in_flen <= FLEN_W'(MAX_FLEN));

  assign used    = head_q - tail_q;
  assign free    = ADDR_W'(RING_BYTES - 1) - used;
  assign need    = (FLEN_W+1)'(flen_q) + (FLEN_W+1)'(PFX_BYTES);
  assign room_ok = (FLEN_W+1)'(free) >= need;

  assign out_free  = !m_tvalid_q || m_axis_tready;
  assign drop_last = (cnt_q == CNT_W'(PFX_BYTES - 1));

  // Prefix of the oldest frame; the top byte arrives on the last read
  assign len_full = {mem_rdata_i, len_q};
  assign len_big  = |len_full[LEN_W-1:ADDR_W];
  assign skip_lo  = (ADDR_W+1)'(PFX_BYTES) + {1'b0, len_full[ADDR_W-1:0]};
  assign drop_all = len_big || (skip_lo >= {1'b0, used});

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_opens ? ST_CHECK : ST_OUT;
        end
      end
      ST_CHECK: begin
        state_d = room_ok ? ST_WRITE : ST_DROP;
      end
      ST_DROP: begin
        if (drop_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_WRITE: begin
        if (cnt_q == SLOT_DATA) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    head_d     = head_q;
    tail_d     = tail_q;
    rem_d      = rem_q;
    disc_d     = disc_q;
    cnt_d      = cnt_q;
    flen_d     = flen_q;
    data_d     = data_q;
    len_d      = len_q;
    res_read_d = res_read_q;
    res_done_d = res_done_q;
    res_over_d = res_over_q;
    m_tdata_d  = m_tdata_q;
    m_tlast_d  = m_tlast_q;
    m_tuser_d  = m_tuser_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    mem_req    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_read_d = 1'b0;
          res_done_d = 1'b0;
          res_over_d = 1'b0;
          cnt_d      = '0;
          flen_d     = in_flen;
          data_d     = in_data;
          if (in_func == FUNC_READ) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = in_raddr;
            res_read_d    = 1'b1;
          end else if (in_first) begin
            rem_d  = '0;
            disc_d = 1'b0;
            if (in_flen > FLEN_W'(MAX_FLEN)) begin
              // swallow the rest of a frame that can never fit
              res_over_d = 1'b1;
              rem_d      = in_flen - FLEN_W'(1);
              disc_d     = (in_flen != FLEN_W'(1));
            end
          end else if (rem_q != '0) begin
            rem_d = rem_q - FLEN_W'(1);
            if (disc_q) begin
              if (rem_q == FLEN_W'(1)) begin
                disc_d = 1'b0;
              end
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = head_q;
              mem_req.wdata = in_data;
              head_d        = head_q + ADDR_W'(1);
              res_done_d    = (rem_q == FLEN_W'(1));
            end
          end
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (!room_ok) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = tail_q;
        end
      end
      ST_DROP: begin
        if (!drop_last) begin
          len_d[cnt_q[LEN_IDX_W-1:0]] = mem_rdata_i;
          mem_req.re    = 1'b1;
          mem_req.raddr = tail_q + ADDR_W'(cnt_q) + ADDR_W'(1);
          cnt_d         = cnt_q + CNT_W'(1);
        end else if (drop_all) begin
          // prefix runs to or past the head: empty the ring
          tail_d = head_q;
        end else begin
          tail_d = tail_q + skip_lo[ADDR_W-1:0];
        end
      end
      ST_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = head_q;
        head_d        = head_q + ADDR_W'(1);
        cnt_d         = cnt_q + CNT_W'(1);
        unique case (cnt_q)
          SLOT_LEN_LO: mem_req.wdata = flen_q[DATA_W-1:0];
          SLOT_LEN_HI: mem_req.wdata = flen_q[FLEN_W-1:DATA_W];
          SLOT_PAD_LO: mem_req.wdata = '0;
          SLOT_PAD_HI: mem_req.wdata = '0;
          SLOT_DATA: begin
            mem_req.wdata = data_q;
            rem_d         = flen_q - FLEN_W'(1);
            res_done_d    = (flen_q == FLEN_W'(1));
          end
          default: mem_req.wdata = '0;
        endcase
      end
      ST_OUT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = '0;
          m_tdata_d[M_RDATA_LSB +: DATA_W] = res_read_q ? mem_rdata_i : '0;
          m_tdata_d[M_HEAD_LSB +: ADDR_W]  = head_q;
          m_tdata_d[M_TAIL_LSB +: ADDR_W]  = tail_q;
          m_tlast_d  = res_done_q;
          m_tuser_d  = M_TUSER_W'(res_over_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      rem_q      <= '0;
      disc_q     <= 1'b0;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      rem_q      <= rem_d;
      disc_q     <= disc_d;
      cnt_q      <= cnt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q     <= flen_d;
    data_q     <= data_d;
    len_q      <= len_d;
    res_read_q <= res_read_d;
    res_done_q <= res_done_d;
    res_over_q <= res_over_d;
    m_tdata_q  <= m_tdata_d;
    m_tlast_q  <= m_tlast_d;
    m_tuser_q  <= m_tuser_d;
  end

  assign mem_req_o     = mem_req;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tvalid = m_tvalid_q;

  `LPFW_ASSERT_NOW(a_mem_single_access, mem_req.we, !mem_req.re, "ring read and write collide")
  `LPFW_ASSERT_NOW(a_discard_owes_bytes, disc_q, rem_q != '0, "discard with no bytes owed")
  `LPFW_ASSERT_NEXT(a_tail_only_on_drop, state_q != ST_DROP, $stable(tail_q), "tail moved outside drop")
  `LPFW_ASSERT_NEXT(a_head_steps_on_write, mem_req.we, head_q == $past(head_q) + ADDR_W'(1), "head did not follow write")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lpfw_pkg::*;

  // Traffic phases: who stalls, and how often.
  localparam int unsigned PACE_SLOW_SINK   = 0;
  localparam int unsigned PACE_SLOW_SOURCE = 1;
  localparam int unsigned PACE_FULL        = 2;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_TICKS = 40;
  localparam int unsigned ITEM_GOAL    = 800;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] head_index;
    logic [ADDR_W-1:0] tail_index;
    logic              frame_done;
    logic              oversize_error;
  } ring_response_t;

  typedef struct packed {
    lpfw_func_e        func;
    logic [DATA_W-1:0] data_byte;
    logic [FLEN_W-1:0] frame_length;
    logic              first_byte;
    logic [ADDR_W-1:0] read_address;
    int unsigned       pace;
    bit                drain_first;
    ring_response_t    want;
  } ring_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  length_prefixed_frame_ring_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the ring and its pointers, advanced as words are generated.
  logic [DATA_W-1:0] ring_mirror [RING_BYTES];
  logic [ADDR_W-1:0] head_pos   = '0;
  logic [ADDR_W-1:0] tail_pos   = '0;
  logic [FLEN_W-1:0] owed_bytes = '0;
  bit                swallowing = 1'b0;
  int unsigned       bytes_written = 0;

  ring_word_t     words_to_send_q[$];
  ring_response_t status_due_q[$];
  ring_word_t     cur_word;
  int unsigned    sent_count   = 0;
  int unsigned    taken_count  = 0;
  int unsigned    traffic_pace = PACE_SLOW_SINK;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;

  // Generator state
  int unsigned gen_pace     = PACE_SLOW_SINK;
  bit          drain_next   = 1'b0;
  int unsigned useful_count = 0;

  // Writes start at zero and advance one by one, so the written bytes are
  // always the first min(bytes_written, RING_BYTES) entries.
  function automatic int unsigned filled_span();
    return (bytes_written >= RING_BYTES) ? RING_BYTES : bytes_written;
  endfunction

  function automatic void store_byte(logic [DATA_W-1:0] b);
    ring_mirror[head_pos] = b;
    head_pos = head_pos + ADDR_W'(1);
    bytes_written++;
  endfunction

  // Drop whole frames at the tail until need bytes are free. Without commit,
  // leave the tail alone and only tell whether every prefix read hits a
  // byte that has been written.
  function automatic bit make_space(int unsigned need, bit commit);
    logic [ADDR_W-1:0] t;
    logic [ADDR_W-1:0] used;
    logic [ADDR_W-1:0] a;
    logic [33:0]       skip;
    bit                ok;
    t    = tail_pos;
    ok   = 1'b1;
    used = head_pos - t;
    while (32'(RING_BYTES - 1) - 32'(used) < need) begin
      skip = 34'(PFX_BYTES);
      for (int i = 0; i < PFX_BYTES; i++) begin
        a = t + ADDR_W'(i);
        if (32'(a) >= filled_span()) ok = 1'b0;
        skip += 34'(ring_mirror[a]) << (8 * i);
      end
      // a prefix that reaches to or past the head empties the ring
      if (skip >= 34'(used)) t = head_pos;
      else t = t + skip[ADDR_W-1:0];
      used = head_pos - t;
    end
    if (commit) tail_pos = t;
    return ok;
  endfunction

  function automatic ring_response_t apply_word(ring_word_t w);
    ring_response_t r;
    r = '0;
    if (w.func == FUNC_READ) begin
      r.read_data = ring_mirror[w.read_address];
    end else if (w.first_byte) begin
      // a new frame start closes whatever frame is open
      owed_bytes = '0;
      swallowing = 1'b0;
      if (w.frame_length != '0) begin
        if (w.frame_length > FLEN_W'(MAX_FLEN)) begin
          r.oversize_error = 1'b1;
          owed_bytes = w.frame_length - FLEN_W'(1);
          swallowing = (owed_bytes != '0);
        end else begin
          void'(make_space(PFX_BYTES + 32'(w.frame_length), 1'b1));
          store_byte(w.frame_length[7:0]);
          store_byte(w.frame_length[15:8]);
          store_byte('0);
          store_byte('0);
          store_byte(w.data_byte);
          owed_bytes = w.frame_length - FLEN_W'(1);
          r.frame_done = (owed_bytes == '0);
        end
      end
    end else if (owed_bytes != '0) begin
      owed_bytes = owed_bytes - FLEN_W'(1);
      if (swallowing) begin
        if (owed_bytes == '0) swallowing = 1'b0;
      end else begin
        store_byte(w.data_byte);
        r.frame_done = (owed_bytes == '0);
      end
    end
    r.head_index = head_pos;
    r.tail_index = tail_pos;
    return r;
  endfunction

  task automatic add_word(lpfw_func_e f, logic [DATA_W-1:0] d, logic [FLEN_W-1:0] len,
                          logic first, logic [ADDR_W-1:0] addr);
    ring_word_t w;
    w.func         = f;
    w.data_byte    = d;
    w.frame_length = len;
    w.first_byte   = first;
    w.read_address = addr;
    w.pace         = gen_pace;
    w.drain_first  = drain_next;
    drain_next     = 1'b0;
    w.want         = apply_word(w);
    words_to_send_q.push_back(w);
  endtask

  task automatic put_append(logic [DATA_W-1:0] d, logic [FLEN_W-1:0] len, logic first);
    add_word(FUNC_APPEND, d, len, first, ADDR_W'($urandom));
  endtask

  // Read only written bytes; the append fields carry noise.
  task automatic put_read(logic [ADDR_W-1:0] addr);
    add_word(FUNC_READ, DATA_W'($urandom), FLEN_W'($urandom), 1'($urandom), addr);
  endtask

  task automatic put_random_read();
    int unsigned span;
    span = filled_span();
    if (span != 0) begin
      if ($urandom_range(0, 9) < 6) put_read(ADDR_W'($urandom_range(0, span - 1)));
      else put_read(head_pos - ADDR_W'(1) -
                    ADDR_W'($urandom_range(0, (span < 16 ? span : 16) - 1)));
      useful_count++;
    end
  endtask

  task automatic random_frame();
    int unsigned len;
    int unsigned sent;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) len = $urandom_range(1, 4);
    else if (roll < 92) len = $urandom_range(5, 16);
    else if (roll < 95) len = $urandom_range(17, 200);
    else len = $urandom_range(MAX_FLEN - 300, MAX_FLEN);
    // keep a long drop pass off prefix bytes that were never written
    if (!make_space(PFX_BYTES + len, 1'b0)) len = $urandom_range(1, 4);
    sent = len;
    // abandon long frames early, and some short ones
    if (len > 200 || $urandom_range(0, 99) < 8) sent = $urandom_range(1, len < 6 ? len : 6);
    for (int k = 0; k < sent; k++) begin
      if ($urandom_range(0, 9) == 0) put_random_read();
      put_append(DATA_W'($urandom), (k == 0) ? FLEN_W'(len) : FLEN_W'($urandom), k == 0);
      useful_count++;
    end
  endtask

  function automatic int unsigned source_gap_pct(int unsigned pace);
    case (pace)
      PACE_SLOW_SINK:   return 9;
      PACE_SLOW_SOURCE: return 81;
      default:          return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(int unsigned pace);
    case (pace)
      PACE_SLOW_SINK:   return 81;
      PACE_SLOW_SOURCE: return 9;
      default:          return 0;
    endcase
  endfunction

  // Driver: present the next word at the falling edge, hold it until taken.
  always @(negedge clk_i) begin
    bit                   hold;
    logic [S_TDATA_W-1:0] tdata_next;
    logic [S_TUSER_W-1:0] tuser_next;
    hold = s_axis_tvalid && (taken_count != sent_count);
    if (rst_ni && !hold && words_to_send_q.size() != 0 &&
        !(words_to_send_q[0].drain_first && (s_axis_tvalid || status_due_q.size() != 0)) &&
        $urandom_range(0, 99) >= source_gap_pct(words_to_send_q[0].pace)) begin
      cur_word = words_to_send_q.pop_front();
      traffic_pace = cur_word.pace;
      tdata_next = '0;
      tdata_next[S_DATA_LSB +: DATA_W]  = cur_word.data_byte;
      tdata_next[S_FLEN_LSB +: FLEN_W]  = cur_word.frame_length;
      tdata_next[S_RADDR_LSB +: ADDR_W] = cur_word.read_address;
      tuser_next = '0;
      tuser_next[S_USER_FUNC]  = cur_word.func;
      tuser_next[S_USER_FIRST] = cur_word.first_byte;
      s_axis_tdata <= tdata_next;
      s_axis_tuser <= tuser_next;
      sent_count++;
      hold = 1'b1;
    end
    s_axis_tvalid <= hold;
  end

  // Sink: stall at random according to the current phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct(traffic_pace));
  end

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: queue the expectation of each taken word, check each result word.
  always @(posedge clk_i) begin
    ring_response_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_due_q.push_back(cur_word.want);
        taken_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due_q.size() == 0) begin
          $display("%0t: result word with none expected, tdata %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = status_due_q.pop_front();
          check_field("read_data", 32'(want.read_data),
                      32'(m_axis_tdata[M_RDATA_LSB +: DATA_W]));
          check_field("head_index", 32'(want.head_index),
                      32'(m_axis_tdata[M_HEAD_LSB +: ADDR_W]));
          check_field("tail_index", 32'(want.tail_index),
                      32'(m_axis_tdata[M_TAIL_LSB +: ADDR_W]));
          check_field("frame_done", 32'(want.frame_done), 32'(m_axis_tlast));
          check_field("oversize_error", 32'(want.oversize_error), 32'(m_axis_tuser[0]));
        end
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned last_pace;
    int unsigned pick;

    // Directed words
    put_append(8'hFF, 16'hFFFF, 1'b0);          // no frame open: ignored
    put_append(8'hFF, 16'd0, 1'b1);             // zero length: writes nothing
    put_append(8'h00, 16'd1, 1'b1);             // one-byte frame done on its opening word
    put_append(8'hFF, 16'd3, 1'b1);
    put_append(8'hAA, 16'd0, 1'b0);
    put_append(8'h55, 16'hFFFF, 1'b0);
    put_read('0);                               // low length byte of the first prefix
    put_read(head_pos - ADDR_W'(1));
    // largest oversize length, two swallowed words, then cut off by a new frame
    put_append(8'h5A, 16'hFFFF, 1'b1);
    put_append(8'h01, 16'd0, 1'b0);
    put_append(8'h02, 16'd0, 1'b0);
    put_append(8'hA5, FLEN_W'(MAX_FLEN + 1), 1'b1);
    // largest frame that fits: drops every frame, then is abandoned
    put_append(8'h11, FLEN_W'(MAX_FLEN), 1'b1);
    put_append(8'h22, 16'd0, 1'b0);
    put_append(8'h33, 16'd2, 1'b1);
    put_append(8'h44, 16'd0, 1'b0);
    // the abandoned prefix claims more than the ring holds: ring empties
    put_append(8'h66, FLEN_W'(MAX_FLEN), 1'b1);
    put_read(head_pos - ADDR_W'(1));

    // Random traffic; the pace changes every third of the run
    last_pace = PACE_SLOW_SINK;
    drain_next = 1'b1;
    while (useful_count < ITEM_GOAL) begin
      gen_pace = (useful_count < ITEM_GOAL / 3)     ? PACE_SLOW_SINK :
                 (useful_count < 2 * ITEM_GOAL / 3) ? PACE_SLOW_SOURCE : PACE_FULL;
      if (gen_pace != last_pace || $urandom_range(0, 99) == 0) drain_next = 1'b1;
      last_pace = gen_pace;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        put_append(DATA_W'($urandom), FLEN_W'($urandom), 1'b0);
      end else if (pick < 5) begin
        put_append(DATA_W'($urandom), '0, 1'b1);
        useful_count++;
      end else if (pick < 8) begin
        put_append(DATA_W'($urandom), FLEN_W'($urandom_range(MAX_FLEN + 1, 16'hFFFF)), 1'b1);
        useful_count++;
        repeat ($urandom_range(0, 4)) put_append(DATA_W'($urandom), FLEN_W'($urandom), 1'b0);
      end else if (pick < 18) begin
        put_random_read();
      end else begin
        random_frame();
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_to_send_q.size() != 0 || s_axis_tvalid || status_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
